### hdl/lcg_pkg.sv
package lcg_pkg;

    // generator constants
    localparam int STATE_W   = 48;
    localparam int WORD_W    = 32;
    localparam int MULT_BITS = 35;
    localparam logic [MULT_BITS-1:0] LCG_MULT = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0]   LCG_INC  = 48'd11;

    // request actions
    localparam logic [2:0] ACT_WORD   = 3'd0;
    localparam logic [2:0] ACT_MODULO = 3'd1;
    localparam logic [2:0] ACT_RANGE  = 3'd2;
    localparam logic [2:0] ACT_LONG   = 3'd3;
    localparam logic [2:0] ACT_SHORT  = 3'd4;
    localparam logic [2:0] ACT_BYTE   = 3'd5;
    localparam logic [2:0] ACT_BIT    = 3'd6;
    localparam logic [2:0] ACT_RELOAD = 3'd7;

    // shared adder operations
    localparam logic [1:0] ALU_MUL   = 2'd0;
    localparam logic [1:0] ALU_INC   = 2'd1;
    localparam logic [1:0] ALU_DIV   = 2'd2;
    localparam logic [1:0] ALU_ADDLO = 2'd3;

    // operands offered to the shared adder
    typedef struct packed {
        logic [STATE_W-1:0] acc;
        logic [STATE_W-1:0] gen;
        logic               mult_bit;
        logic [WORD_W:0]    partial;
        logic [WORD_W-1:0]  divisor;
        logic [WORD_W-1:0]  rem;
        logic [WORD_W-1:0]  low;
    } t_alu_operands;

    // core status toward the output stage
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

endpackage

### hdl/lcg_alu.sv
module lcg_alu (
    input  logic [1:0]                  i_op,
    input  lcg_pkg::t_alu_operands      i_opnd,
    output logic [lcg_pkg::STATE_W:0]   o_sum
);

    logic [lcg_pkg::STATE_W-1:0] w_a;
    logic [lcg_pkg::STATE_W-1:0] w_b;
    logic                        w_cin;

    // operand selection per operation
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_cin = 1'b0;
        unique case (i_op)
            lcg_pkg::ALU_MUL: begin
                // horner step: acc*2 + (multiplier bit ? state : 0)
                w_a = {i_opnd.acc[lcg_pkg::STATE_W-2:0], 1'b0};
                w_b = i_opnd.mult_bit ? i_opnd.gen : '0;
            end
            lcg_pkg::ALU_INC: begin
                w_a = i_opnd.acc;
                w_b = lcg_pkg::LCG_INC;
            end
            lcg_pkg::ALU_DIV: begin
                // trial subtract, carry out set when partial >= divisor
                w_a   = {{(lcg_pkg::STATE_W-lcg_pkg::WORD_W-1){1'b0}}, i_opnd.partial};
                w_b   = ~{{(lcg_pkg::STATE_W-lcg_pkg::WORD_W){1'b0}}, i_opnd.divisor};
                w_cin = 1'b1;
            end
            lcg_pkg::ALU_ADDLO: begin
                w_a = {{(lcg_pkg::STATE_W-lcg_pkg::WORD_W){1'b0}}, i_opnd.rem};
                w_b = {{(lcg_pkg::STATE_W-lcg_pkg::WORD_W){1'b0}}, i_opnd.low};
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // the one shared adder
    assign o_sum = {1'b0, w_a} + {1'b0, w_b} + {{lcg_pkg::STATE_W{1'b0}}, w_cin};

endmodule

### hdl/lcg_core.sv
module lcg_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2:0]                  i_action,
    input  logic [31:0]                 i_modulus,
    input  logic [31:0]                 i_low_bound,
    input  logic [31:0]                 i_high_bound,
    input  logic                        i_seed_we,
    input  logic [47:0]                 i_seed_value,
    input  logic                        i_take,
    output lcg_pkg::t_core_status       o_status,
    output logic [63:0]                 o_value,
    output logic                        o_error
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_INC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ADDLO = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [5:0] MUL_LAST = 6'(lcg_pkg::MULT_BITS - 1);
    localparam logic [5:0] DIV_LAST = 6'(lcg_pkg::WORD_W - 1);

    logic [2:0]  r_st,     n_st;
    logic [47:0] r_seed,   n_seed;
    logic [47:0] r_gen,    n_gen;
    logic [47:0] r_acc,    n_acc;
    logic [2:0]  r_act,    n_act;
    logic [31:0] r_div,    n_div;
    logic [31:0] r_lo,     n_lo;
    logic [5:0]  r_cnt,    n_cnt;
    logic [31:0] r_first,  n_first;
    logic        r_second, n_second;
    logic [31:0] r_word,   n_word;
    logic [31:0] r_rem,    n_rem;
    logic [63:0] r_value,  n_value;
    logic        r_error,  n_error;

    logic [1:0]               w_op;
    lcg_pkg::t_alu_operands   w_opnd;
    logic [48:0]              w_sum;
    logic [31:0]              w_span;
    logic [32:0]              w_partial;
    logic [31:0]              w_rem_next;
    logic [47:0]              w_new_gen;

    // span of the range action, 32-bit wrap
    assign w_span    = i_high_bound - i_low_bound + 32'd1;
    assign w_partial = {r_rem, r_word[31]};
    assign w_new_gen = w_sum[47:0];

    // operand set for the shared adder
    always_comb begin
        w_opnd.acc      = r_acc;
        w_opnd.gen      = r_gen;
        w_opnd.mult_bit = lcg_pkg::LCG_MULT[r_cnt];
        w_opnd.partial  = w_partial;
        w_opnd.divisor  = r_div;
        w_opnd.rem      = r_rem;
        w_opnd.low      = r_lo;
        unique case (r_st)
            S_INC:   w_op = lcg_pkg::ALU_INC;
            S_DIV:   w_op = lcg_pkg::ALU_DIV;
            S_ADDLO: w_op = lcg_pkg::ALU_ADDLO;
            default: w_op = lcg_pkg::ALU_MUL;
        endcase
    end

    lcg_alu u_alu (
        .i_op   (w_op),
        .i_opnd (w_opnd),
        .o_sum  (w_sum)
    );

    // restoring divider step: keep the difference when no borrow
    assign w_rem_next = w_sum[48] ? w_sum[31:0] : w_partial[31:0];

    // sequencer
    always_comb begin
        n_st     = r_st;
        n_seed   = r_seed;
        n_gen    = r_gen;
        n_acc    = r_acc;
        n_act    = r_act;
        n_div    = r_div;
        n_lo     = r_lo;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_second = r_second;
        n_word   = r_word;
        n_rem    = r_rem;
        n_value  = r_value;
        n_error  = r_error;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_act    = i_action;
                    n_lo     = i_low_bound;
                    n_div    = (i_action == lcg_pkg::ACT_MODULO) ? i_modulus : w_span;
                    n_second = 1'b0;
                    n_error  = 1'b0;
                    n_value  = '0;
                    if (i_action == lcg_pkg::ACT_RELOAD) begin
                        n_gen = r_seed;
                        n_st  = S_DONE;
                    end else begin
                        n_acc = '0;
                        n_cnt = MUL_LAST;
                        n_st  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_acc = w_sum[47:0];
                if (r_cnt == 6'd0) begin
                    n_st = S_INC;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_INC: begin
                n_gen = w_new_gen;
                n_st  = S_DONE;
                case (r_act)
                    lcg_pkg::ACT_LONG: begin
                        if (!r_second) begin
                            n_first  = w_new_gen[47:16];
                            n_second = 1'b1;
                            n_acc    = '0;
                            n_cnt    = MUL_LAST;
                            n_st     = S_MUL;
                        end else begin
                            n_value = {r_first, w_new_gen[47:16]};
                        end
                    end
                    lcg_pkg::ACT_MODULO, lcg_pkg::ACT_RANGE: begin
                        if (r_div == 32'd0) begin
                            n_error = 1'b1;
                        end else begin
                            n_word = w_new_gen[47:16];
                            n_rem  = '0;
                            n_cnt  = DIV_LAST;
                            n_st   = S_DIV;
                        end
                    end
                    lcg_pkg::ACT_SHORT: n_value = {48'd0, w_new_gen[47:32]};
                    lcg_pkg::ACT_BYTE:  n_value = {56'd0, w_new_gen[47:40]};
                    lcg_pkg::ACT_BIT:   n_value = {63'd0, w_new_gen[24]};
                    default:            n_value = {32'd0, w_new_gen[47:16]};
                endcase
            end
            S_DIV: begin
                n_rem  = w_rem_next;
                n_word = {r_word[30:0], 1'b0};
                if (r_cnt == 6'd0) begin
                    if (r_act == lcg_pkg::ACT_MODULO) begin
                        n_value = {32'd0, w_rem_next};
                        n_st    = S_DONE;
                    end else begin
                        n_st = S_ADDLO;
                    end
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_ADDLO: begin
                n_value = {32'd0, w_sum[31:0]};
                n_st    = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
        // seed write reloads the generator
        if (i_seed_we) begin
            n_seed = i_seed_value;
            n_gen  = i_seed_value;
        end
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_seed <= '0;
            r_gen  <= '0;
        end else begin
            r_st   <= n_st;
            r_seed <= n_seed;
            r_gen  <= n_gen;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_act    <= n_act;
        r_div    <= n_div;
        r_lo     <= n_lo;
        r_cnt    <= n_cnt;
        r_first  <= n_first;
        r_second <= n_second;
        r_word   <= n_word;
        r_rem    <= n_rem;
        r_value  <= n_value;
        r_error  <= n_error;
    end

    assign o_status.busy = (r_st != S_IDLE);
    assign o_status.done = (r_st == S_DONE);
    assign o_value       = r_value;
    assign o_error       = r_error;

endmodule

### hdl/lcg48_random_generator.sv
// 48-bit linear congruential random generator.
// Input channel: i_valid / o_stall with i_action and its operands; a transfer
// happens on a rising edge with i_valid high and o_stall low. One request is
// processed at a time; o_stall stays high from the transfer until the result
// has been handed to the output register.
// Output channel: o_valid / i_stall with o_value and o_error. The output
// register holds the result until the receiver takes it, and the next request
// may be accepted while it waits.
// Configuration: i_seed_we writes i_seed_value, which also loads the state.
// After the input transfer: reload copies the seed into the state; word, short,
// byte and bit take one state advance; modulo adds a division, range a division
// and the low-bound add, long two advances (zero divisor or span ends after the
// advance). Each state advance is a 35-step bit-serial multiply plus an
// increment step, and modulo/range add a 32-step restoring division, all through
// one shared 48-bit adder; o_stall falls in the same cycle as o_valid rises.
// A stalled receiver holds the finished result in the core until the output
// register frees up.
// Reset (synchronous, active low) clears seed and state to zero and empties
// the output register.
module lcg48_random_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic [31:0]        i_modulus,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_value,
    output logic               o_error,
    input  logic               i_seed_we,
    input  logic [47:0]        i_seed_value
);

    lcg_pkg::t_core_status w_status;
    logic [63:0]           w_value;
    logic                  w_error;
    logic                  w_start;
    logic                  w_take;

    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_error;

    assign w_start = i_valid && !w_status.busy;
    assign w_take  = w_status.done && (!r_out_valid || !i_stall);

    lcg_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_action     (i_action),
        .i_modulus    (i_modulus),
        .i_low_bound  (i_low_bound),
        .i_high_bound (i_high_bound),
        .i_seed_we    (i_seed_we),
        .i_seed_value (i_seed_value),
        .i_take       (w_take),
        .o_status     (w_status),
        .o_value      (w_value),
        .o_error      (w_error)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_value <= w_value;
            r_out_error <= w_error;
        end
    end

    assign o_stall = w_status.busy;
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

endmodule

### hdl/lcg_checker.sv
module lcg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic [31:0]        i_modulus,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [63:0]        o_value,
    input  logic               o_error,
    input  logic               i_seed_we,
    input  logic [47:0]        i_seed_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_error))
        else $error("stalled result changed");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after input transfer");

    // an error result carries a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_value == 64'd0)
        else $error("error result with nonzero value");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind lcg48_random_generator lcg_checker u_lcg_checker (.*);
